@@ src/ssmd_pkg.sv @@
// -----------------------------------------------------------------------------
// ssmd_pkg
// Shared types, constants and the segment table for the seven-segment driver.
// -----------------------------------------------------------------------------
package ssmd_pkg;

   // number of multiplexed digit positions
   localparam int DIGIT_COUNT = 4;
   localparam int POS_W       = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

   // stream payload widths
   localparam int VALUE_W    = 32;
   localparam int POINT_W    = 3;
   localparam int SEL_W      = 4;
   localparam int REQ_DATA_W = 40;  // value + point_position, padded to bytes
   localparam int RSP_DATA_W = 8;   // serial_data + digit_select_n, padded

   // operation codes carried in req_tuser
   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_REFRESH = 1'b1;

   // divide by ten: q = (n * RECIP_10) >> RECIP_SHIFT, exact for 32-bit n
   localparam logic [VALUE_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
   localparam int                 RECIP_SHIFT = 35;
   localparam int                 PROD_W      = 2 * VALUE_W;

   localparam logic [7:0] DP_BIT = 8'h80;

   typedef logic [DIGIT_COUNT-1:0] enables_type;
   typedef logic [POS_W-1:0]       pos_type;

   // controller to datapath
   typedef struct packed {
      logic load_capture;
      logic refresh_capture;
      logic mul_step;
      logic div_step;
      logic shift_step;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic digit_last;
      logic bit_last;
   } sts_type;

   // segment pattern of one decimal digit, g..a in bits 6..0
   function automatic logic [7:0] seg_of(input logic [3:0] digit);
      logic [7:0] pat;
      case (digit)
         4'd0: pat = 8'h3F;
         4'd1: pat = 8'h06;
         4'd2: pat = 8'h5B;
         4'd3: pat = 8'h4F;
         4'd4: pat = 8'h66;
         4'd5: pat = 8'h6D;
         4'd6: pat = 8'h7D;
         4'd7: pat = 8'h07;
         4'd8: pat = 8'h7F;
         4'd9: pat = 8'h6F;
         default: pat = 8'h00;
      endcase
      return pat;
   endfunction

   // low four enable bits as seen on the port
   function automatic logic [SEL_W-1:0] sel_of(input enables_type en);
      logic [7:0] wide;
      wide = 8'(en);
      return wide[SEL_W-1:0];
   endfunction

endpackage

@@ src/seven_segment_mux_driver_top.sv @@
// Four-digit multiplexed seven-segment driver. A load transaction (req_tuser = 0)
// splits the 32-bit value into its four lowest decimal digits, one digit per
// multiply/correct state pair through a reciprocal multiply and correction; no
// further transaction is taken until the load is done, and it produces no output.
// A refresh transaction (req_tuser = 1) shifts the current digit's pattern out MSB
// first as eight response transactions, one per cycle while rsp_tready is high;
// the eighth has rsp_tlast set (latch strobe) and carries the new active-low
// enables, ones digit first. One transaction is in work at a time.
// -----------------------------------------------------------------------------
// seven_segment_mux_driver_top
// Top level: controller and datapath of the multiplexed display driver.
// -----------------------------------------------------------------------------
module seven_segment_mux_driver_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ssmd_pkg::REQ_DATA_W-1:0]   req_tdata,  // [31:0] value, [34:32] point_position
   input  logic                              req_tuser,  // [0] operation
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ssmd_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // [0] serial_data, [4:1] digit_select_n
   output logic                              rsp_tlast
);
   import ssmd_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencer
   ssmd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // datapath
   ssmd_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

endmodule

@@ src/ssmd_ctrl.sv @@
// -----------------------------------------------------------------------------
// ssmd_ctrl
// Sequencer: digit conversion steps on load, bit-by-bit shift-out on refresh.
// -----------------------------------------------------------------------------
module ssmd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic             req_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output ssmd_pkg::cmd_type cmd,
   input  ssmd_pkg::sts_type sts
);
   import ssmd_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_MUL   = 2'd1;
   localparam logic [1:0] S_DIV   = 2'd2;
   localparam logic [1:0] S_SHIFT = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser == OP_REFRESH) begin
                  cmd.refresh_capture = 1'b1;
                  state_in            = S_SHIFT;
               end else begin
                  cmd.load_capture = 1'b1;
                  state_in         = S_MUL;
               end
            end
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            state_in     = sts.digit_last ? S_IDLE : S_MUL;
         end
         S_SHIFT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               cmd.shift_step = 1'b1;
               if (sts.bit_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ src/ssmd_datapath.sv @@
// -----------------------------------------------------------------------------
// ssmd_datapath
// Decimal split by reciprocal multiply, pattern store, shift register, enables.
// -----------------------------------------------------------------------------
module ssmd_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  ssmd_pkg::cmd_type                   cmd,
   output ssmd_pkg::sts_type                   sts,
   input  logic [ssmd_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic [ssmd_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast
);
   import ssmd_pkg::*;

   logic [VALUE_W-1:0] num_ff, num_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [POINT_W-1:0] point_ff, point_in;
   pos_type            digit_ff, digit_in;
   logic [7:0]         pat_ff [DIGIT_COUNT];
   logic [7:0]         shift_ff, shift_in;
   logic [2:0]         bit_ff, bit_in;
   pos_type            scan_ff, scan_in;
   enables_type        enables_ff, enables_in;

   logic [VALUE_W-4:0] quot;
   logic [3:0]         quot_x10;
   logic [3:0]         rem;
   logic [7:0]         new_pat;
   logic               point_hit;
   logic               digit_last;
   logic               bit_last;
   enables_type        enables_next;
   logic [SEL_W-1:0]   sel_out;

   // one decimal digit per multiply/correct pair
   assign quot       = prod_ff[PROD_W-1:RECIP_SHIFT];
   assign quot_x10   = 4'(quot[3:0] << 3) + 4'(quot[3:0] << 1);
   assign rem        = num_ff[3:0] - quot_x10;
   assign point_hit  = (4'(point_ff) == 4'(digit_ff));
   assign new_pat    = seg_of(rem) | (point_hit ? DP_BIT : 8'h00);
   assign digit_last = (32'(digit_ff) == 32'(DIGIT_COUNT - 1));

   // shift-out and enables for the current scan position
   assign bit_last     = (bit_ff == 3'd7);
   assign enables_next = ~(enables_type'(1) << scan_ff);
   assign sel_out      = bit_last ? sel_of(enables_next) : sel_of(enables_ff);

   assign sts.digit_last = digit_last;
   assign sts.bit_last   = bit_last;

   // rsp_tdata: [0] serial_data, [4:1] digit_select_n, zero padded
   assign rsp_tdata = RSP_DATA_W'({sel_out, shift_ff[7]});
   assign rsp_tlast = bit_last;

   // conversion and shift registers, next values
   always_comb begin
      num_in   = num_ff;
      prod_in  = prod_ff;
      point_in = point_ff;
      digit_in = digit_ff;
      shift_in = shift_ff;
      if (cmd.load_capture) begin
         num_in   = req_tdata[VALUE_W-1:0];
         point_in = req_tdata[VALUE_W +: POINT_W];
         digit_in = '0;
      end
      if (cmd.mul_step) begin
         prod_in = num_ff * RECIP_10;
      end
      if (cmd.div_step) begin
         num_in   = VALUE_W'(quot);
         digit_in = digit_last ? pos_type'(0) : pos_type'(digit_ff + pos_type'(1));
      end
      if (cmd.refresh_capture) begin
         shift_in = pat_ff[scan_ff];
      end else if (cmd.shift_step) begin
         shift_in = {shift_ff[6:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      num_ff   <= num_in;
      prod_ff  <= prod_in;
      point_ff <= point_in;
      digit_ff <= digit_in;
      shift_ff <= shift_in;
   end

   // scan position, bit count and held enables
   always_comb begin
      bit_in     = bit_ff;
      scan_in    = scan_ff;
      enables_in = enables_ff;
      if (cmd.refresh_capture) begin
         bit_in = '0;
      end else if (cmd.shift_step) begin
         bit_in = bit_ff + 3'd1;
         if (bit_last) begin
            enables_in = enables_next;
            scan_in    = (32'(scan_ff) == 32'(DIGIT_COUNT - 1)) ? pos_type'(0)
                                                                 : pos_type'(scan_ff + pos_type'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff     <= '0;
         scan_ff    <= '0;
         enables_ff <= '1;
      end else begin
         bit_ff     <= bit_in;
         scan_ff    <= scan_in;
         enables_ff <= enables_in;
      end
   end

   // digit pattern store
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIGIT_COUNT; i++) begin
            pat_ff[i] <= '0;
         end
      end else if (cmd.div_step) begin
         pat_ff[digit_ff] <= new_pat;
      end
   end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multiplexed seven-segment driver. Number loads
// and refresh ticks go in on the request stream. A scoreboard keeps its own
// digit patterns, scan position and held enables. It checks every serial bit,
// latch strobe and enable word that comes back. Both streams idle at random.
// -----------------------------------------------------------------------------
module tb_top;

   import ssmd_pkg::*;

   localparam int ITEM_TOTAL  = 234;
   localparam int STALL_LIMIT = 3000;
   localparam int PRINT_CAP   = 40;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = OP_LOAD;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   int idle_cycles = 0;

   // expected display traffic: digit patterns, scan position and held enables
   class display_scoreboard;
      typedef struct {
         bit             serial;
         bit             strobe;
         bit [SEL_W-1:0] sel;
      } shift_bit_type;

      bit [7:0]             seg_code [10];
      bit [7:0]             digit_pat [DIGIT_COUNT];
      bit [POS_W-1:0]       scan_pos;
      bit [DIGIT_COUNT-1:0] enables;
      shift_bit_type        pending_bits [$];
      int                   mismatches;
      int                   loads;
      int                   refreshes;
      int                   bits_checked;

      function new();
         seg_code = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
                      8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};
         foreach (digit_pat[i]) digit_pat[i] = 8'h00;
         scan_pos     = '0;
         enables      = '1;
         mismatches   = 0;
         loads        = 0;
         refreshes    = 0;
         bits_checked = 0;
      endfunction

      // one accepted request transaction
      function void note_request(bit op, bit [VALUE_W-1:0] value, bit [POINT_W-1:0] point);
         int unsigned   rest;
         bit [7:0]      pat;
         shift_bit_type e;
         if (op == OP_LOAD) begin
            // split into the lowest decimal digits, ones digit first
            rest = value;
            for (int i = 0; i < DIGIT_COUNT; i++) begin
               pat = seg_code[rest % 10];
               if (point == i) pat = pat | DP_BIT;
               digit_pat[i] = pat;
               rest = rest / 10;
            end
            loads++;
         end else begin
            // shift the current digit out msb first, latch on the eighth bit
            pat = digit_pat[scan_pos];
            for (int k = 0; k < 8; k++) begin
               if (k == 7) begin
                  enables           = '1;
                  enables[scan_pos] = 1'b0;
               end
               e.serial = pat[7-k];
               e.strobe = (k == 7);
               e.sel    = SEL_W'(enables);
               pending_bits.push_back(e);
            end
            scan_pos = (scan_pos == DIGIT_COUNT - 1) ? '0 : scan_pos + 1'b1;
            refreshes++;
         end
      endfunction

      task report(string what, int unsigned got, int unsigned want);
         mismatches++;
         if (mismatches <= PRINT_CAP)
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
      endtask

      // one accepted response transaction against the oldest expectation
      task check_result(bit [RSP_DATA_W-1:0] data, bit last);
         shift_bit_type e;
         if (pending_bits.size() == 0) begin
            report("unexpected response", data, 0);
         end else begin
            e = pending_bits.pop_front();
            bits_checked++;
            if (data[0] != e.serial) report("serial_data", data[0], e.serial);
            if (last != e.strobe) report("latch_strobe", last, e.strobe);
            if (data[SEL_W:1] != e.sel) report("digit_select_n", data[SEL_W:1], e.sel);
         end
      endtask
   endclass

   display_scoreboard board = new();

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   seven_segment_mux_driver_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [31:0] value, [34:32] point_position
      .req_tuser  (req_tuser),   // [0] operation
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [0] serial_data, [4:1] digit_select_n
      .rsp_tlast  (rsp_tlast)
   );

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // one request transaction, held until the block takes it
   task send_item(bit op, bit [VALUE_W-1:0] value, bit [POINT_W-1:0] point, int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(REQ_DATA_W - VALUE_W - POINT_W){1'b0}}, point, value};
      do @(posedge clock); while (!req_tready);
   endtask

   task send_refresh(int gap);
      send_item(OP_REFRESH, $urandom, $urandom_range(0, 7), gap);
   endtask

   // stop sending and let every expected response come back
   task drain_display();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending_bits.size() != 0) @(posedge clock);
   endtask

   // response side back-pressure, with long stretches of steady ready
   initial begin
      int hold;
      int stall;
      @(posedge clock);
      forever begin
         hold = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 6);
         rsp_tready <= 1'b1;
         repeat (hold) @(posedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // transaction monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            board.note_request(req_tuser, req_tdata[VALUE_W-1:0],
                               req_tdata[VALUE_W+POINT_W-1:VALUE_W]);
         if (rsp_tvalid && rsp_tready)
            board.check_result(rsp_tdata, rsp_tlast);
      end
   end

   // watchdog on cycles with no transaction on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // stimulus
   initial begin
      int unsigned value;
      int          gap;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // scan from reset state, then numbers that use every digit code
      send_refresh(pick_gap());
      send_item(OP_LOAD, 32'd0, 3'd0, pick_gap());
      repeat (3) send_refresh(pick_gap());
      send_item(OP_LOAD, 32'hFFFF_FFFF, 3'd4, pick_gap());
      repeat (4) send_refresh(pick_gap());
      send_item(OP_LOAD, 32'd6180, 3'd7, pick_gap());
      repeat (4) send_refresh(pick_gap());
      send_item(OP_LOAD, 32'd34, 3'd1, pick_gap());
      repeat (4) send_refresh(pick_gap());
      send_item(OP_LOAD, 32'd98765, 3'd3, pick_gap());
      send_item(OP_LOAD, 32'd4321, 3'd2, pick_gap());
      repeat (4) send_refresh(pick_gap());

      // random loads and refresh ticks, some runs without gaps
      for (int i = 0; i < ITEM_TOTAL; i++) begin
         if (i == ITEM_TOTAL / 2) drain_display();
         gap = ((i / 40) % 3 == 1) ? 0 : pick_gap();
         if ($urandom_range(0, 99) < 35) begin
            case ($urandom_range(0, 3))
               0: value = $urandom_range(0, 9999);
               1: value = $urandom_range(0, 99);
               default: value = $urandom;
            endcase
            send_item(OP_LOAD, value, $urandom_range(0, 7), gap);
         end else begin
            send_refresh(gap);
         end
      end

      drain_display();
      repeat (20) @(posedge clock);
      if (board.pending_bits.size() != 0)
         board.report("responses still pending", board.pending_bits.size(), 0);

      $display("tb_top: %0d number loads and %0d refresh ticks sent, %0d shifted bits checked",
               board.loads, board.refreshes, board.bits_checked);
      if (board.mismatches == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule

@@ files.f @@
src/ssmd_pkg.sv
src/ssmd_ctrl.sv
src/ssmd_datapath.sv
src/seven_segment_mux_driver_top.sv
tb/tb_top.sv
